FILE: rtl/core/wbps_pkg.sv
// Package for the wildcard byte pattern search unit.
// Holds the payload structs, the shared cell configuration struct and the
// register index codes. No dependencies.
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = 5;
  localparam int PAT_IDX_W         = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int ADDR_W            = 64;
  localparam int COUNT_W           = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  // What every cell needs to judge its own window position.
  typedef struct packed {
    logic [8*MAX_PATTERN_BYTES-1:0] pattern;
    logic [MAX_PATTERN_BYTES-1:0]   care_mask;
    logic [LEN_W-1:0]               eff_len;
  } match_cfg_t;

endpackage

FILE: rtl/core/wbps_cell.sv
// One window cell: holds one byte of the window and compares the byte
// entering it against its pattern byte. Depends on wbps_pkg.
module wbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [7:0]          byte_in,
  input  wbps_pkg::match_cfg_t cfg,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import wbps_pkg::*;

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  generate
    if (CELL_IDX < MAX_PATTERN_BYTES) begin : g_cmp
      logic [LEN_W-1:0]     pos;
      logic [PAT_IDX_W-1:0] pidx;

      // Cell k meets pattern byte eff_len-1-k; outside the pattern it passes.
      assign pos  = cfg.eff_len - LEN_W'(CELL_IDX + 1);
      assign pidx = pos[PAT_IDX_W-1:0];
      assign hit  = (cfg.eff_len <= LEN_W'(CELL_IDX)) || !cfg.care_mask[pidx] ||
                    (cfg.pattern[{pidx, 3'b000} +: 8] == byte_in);
    end else begin : g_pass
      assign hit = 1'b1;
    end
  endgenerate

endmodule

FILE: rtl/core/wbps_skid.sv
// Two-entry output buffer (output register plus skid register) for results.
// Depends on wbps_pkg.
module wbps_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  wbps_pkg::out_item_t res_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wbps_pkg::out_item_t out_item
);
  import wbps_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t skid_item_r, skid_item_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    priority if (skid_valid_r) begin
      if (take) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_item_nxt  = res_item;
        out_valid_nxt = 1'b1;
      end else begin
        skid_item_nxt  = res_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end else begin
      // Idle: hold both entries.
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/core/wildcard_byte_pattern_search_unit.sv
// Wildcard byte pattern search: one byte per cycle unless the output buffer
// is full; the result of the byte that completes a match or ends the region
// is registered in the output buffer. The window compare is spread over a row
// of cells, each checking its own window byte in parallel.
// Reset (synchronous, rst_n low) clears the byte count, match flag and the
// output buffer, and loads register reset values; window bytes are not cleared.
module wildcard_byte_pattern_search_unit #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  wbps_pkg::in_item_t                     in_item,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output wbps_pkg::out_item_t                    out_item,
  input  logic                                   cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import wbps_pkg::*;

  // Longest usable pattern: the window depth or the register width.
  localparam int LEN_CAP = (PATTERN_MAX < MAX_PATTERN_BYTES) ? PATTERN_MAX : MAX_PATTERN_BYTES;

  // Configuration registers
  logic [63:0]                  pattern_lo_r;
  logic [63:0]                  pattern_hi_r;
  logic [MAX_PATTERN_BYTES-1:0] care_mask_r;
  logic [LEN_W-1:0]             pattern_length_r;
  logic [ADDR_W-1:0]            region_base_r;

  // Region state
  logic [COUNT_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic               matched_r, matched_nxt;

  logic               accept;
  logic               saturated;
  logic               shift_en;
  logic [COUNT_W-1:0] count_new;
  logic [LEN_W-1:0]   eff_len;
  logic               hit_now;
  match_cfg_t         cell_cfg;
  logic [7:0]         chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit;
  logic               res_valid;
  out_item_t          res_item;
  logic               buf_full;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r     <= '0;
      pattern_hi_r     <= '0;
      care_mask_r      <= '1;
      pattern_length_r <= LEN_W'(1);
      region_base_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LO:     pattern_lo_r     <= cfg_wdata;
        REG_PATTERN_HI:     pattern_hi_r     <= cfg_wdata;
        REG_CARE_MASK:      care_mask_r      <= cfg_wdata[MAX_PATTERN_BYTES-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[LEN_W-1:0];
        REG_REGION_BASE:    region_base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the length: zero acts as one, too long saturates to the cap.
  always_comb begin
    eff_len = pattern_length_r;
    if (pattern_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(LEN_CAP)) begin
      eff_len = LEN_W'(LEN_CAP);
    end
  end

  assign cell_cfg.pattern   = {pattern_hi_r, pattern_lo_r};
  assign cell_cfg.care_mask = care_mask_r;
  assign cell_cfg.eff_len   = eff_len;

  assign accept    = in_valid && !in_stall;
  assign saturated = &bytes_seen_r;
  // Advance the window only while still hunting and the count has room.
  assign shift_en  = accept && !matched_r && !saturated;
  assign count_new = bytes_seen_r + COUNT_W'(1);

  // Row of window cells: cell 0 takes the new byte, each cell hands its
  // byte to the next one on every shift.
  assign chain[0] = in_item.data_byte;

  generate
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      if (g < PATTERN_MAX - 1) begin : g_mid
        wbps_cell #(.CELL_IDX(g)) u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .byte_in  (chain[g]),
          .cfg      (cell_cfg),
          .byte_out (chain[g+1]),
          .hit      (hit[g])
        );
      end else begin : g_end
        wbps_cell #(.CELL_IDX(g)) u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .byte_in  (chain[g]),
          .cfg      (cell_cfg),
          .byte_out (),
          .hit      (hit[g])
        );
      end
    end
  endgenerate

  // A match needs a full pattern's worth of bytes from this region.
  assign hit_now = shift_en && (count_new >= COUNT_W'(eff_len)) && (&hit);

  // One transaction per byte at most: a hit, or a miss at the region end.
  assign res_valid = accept && (hit_now || (in_item.last_byte && !matched_r));
  assign res_item.found         = hit_now;
  assign res_item.match_address = hit_now ?
      region_base_r + ADDR_W'(count_new - COUNT_W'(eff_len)) : '0;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    matched_nxt    = matched_r;
    if (accept) begin
      if (in_item.last_byte) begin
        // Drop the region state; registers hold.
        bytes_seen_nxt = '0;
        matched_nxt    = 1'b0;
      end else begin
        if (shift_en) begin
          bytes_seen_nxt = count_new;
        end
        if (hit_now) begin
          matched_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      matched_r    <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      matched_r    <= matched_nxt;
    end
  end

  // Output register plus skid entry: input stalls only when both are full.
  wbps_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign in_stall = buf_full;

endmodule

FILE: rtl/core/wbps_checker.sv
// Port-level checks for the wildcard byte pattern search unit, with the bind
// that attaches them to the top level. Depends on wbps_pkg.
module wbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wbps_pkg::out_item_t out_item
);
  import wbps_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // A region end without match carries a zero address.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.match_address == '0)
    else $error("miss result with nonzero address");

  // Input stalls only while a result is waiting in the output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: tb/sv/wbps_scan_checker.sv
`timescale 1ns / 1ps
// Scoreboard for wildcard_byte_pattern_search_unit. It mirrors the registers and
// the region state, predicts every scan result and compares it with the output.
// Depends on wbps_pkg.
module wbps_scan_checker #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  wbps_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  wbps_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              results_due
);
  import wbps_pkg::*;

  localparam int LEN_CAP = (PATTERN_MAX < MAX_PATTERN_BYTES) ? PATTERN_MAX : MAX_PATTERN_BYTES;

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [63:0] base_addr;
  logic [15:0] care;
  logic [4:0]  pat_len;

  logic [7:0]  recent_bytes [PATTERN_MAX];
  logic [31:0] region_count;
  logic        region_done;
  out_item_t   scan_results_due [$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns scan check: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_region();
    int k;
    for (k = 0; k < PATTERN_MAX; k++) recent_bytes[k] = '0;
    region_count = '0;
    region_done  = 1'b0;
  endtask

  // Advance the window by one byte and queue the result it causes, if any.
  task automatic scan_byte(input in_item_t item);
    int unsigned  len;
    int           k;
    logic         hit;
    logic [127:0] pattern;
    out_item_t    res;
    if (!region_done && region_count != '1) begin
      len = (pat_len == 0) ? 1 : ((pat_len > LEN_CAP) ? LEN_CAP : pat_len);
      for (k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = item.data_byte;
      region_count++;
      pattern = {pat_hi, pat_lo};
      hit = (region_count >= len);
      for (k = 0; k < len; k++) begin
        if (care[k] && pattern[8*k +: 8] != recent_bytes[len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        res.found         = 1'b1;
        res.match_address = base_addr + 64'(region_count - len);
        scan_results_due  = {scan_results_due, res};
        region_done = 1'b1;
      end
    end
    if (item.last_byte) begin
      if (!region_done) begin
        res.found         = 1'b0;
        res.match_address = '0;
        scan_results_due  = {scan_results_due, res};
      end
      clear_region();
    end
  endtask

  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      pat_lo    = '0;
      pat_hi    = '0;
      care      = 16'hFFFF;
      pat_len   = 5'd1;
      base_addr = '0;
      clear_region();
      scan_results_due.delete();
    end else begin
      // A byte accepted at this edge still sees the old register values.
      if (in_valid && !in_stall) scan_byte(in_item);
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LO:     pat_lo    = cfg_wdata;
          REG_PATTERN_HI:     pat_hi    = cfg_wdata;
          REG_CARE_MASK:      care      = cfg_wdata[15:0];
          REG_PATTERN_LENGTH: pat_len   = cfg_wdata[4:0];
          REG_REGION_BASE:    base_addr = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (scan_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0b address=%h",
                                    out_item.found, out_item.match_address));
        end else begin
          due = scan_results_due.pop_front();
          if (out_item.found !== due.found)
            report_mismatch($sformatf("found %0b, expected %0b", out_item.found, due.found));
          if (out_item.match_address !== due.match_address)
            report_mismatch($sformatf("match_address %h, expected %h",
                                      out_item.match_address, due.match_address));
        end
      end
    end
    results_due <= scan_results_due.size();
  end

endmodule

FILE: tb/sv/wildcard_byte_pattern_search_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for wildcard_byte_pattern_search_unit: clock, reset, register
// settings, directed and random byte regions, and output backpressure.
// Depends on wbps_pkg, the unit and wbps_scan_checker.
module wildcard_byte_pattern_search_unit_tb;
  import wbps_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int results_due;

  // Register values as last written; regions are built from these.
  logic [63:0] set_lo;
  logic [63:0] set_hi;
  logic [63:0] set_base;
  logic [15:0] set_care;
  logic [4:0]  set_len;

  int unsigned bytes_sent = 0;
  bit          rush = 1'b0;              // no input gaps while set
  stall_mode_t stall_mode = STALL_LIGHT;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  wildcard_byte_pattern_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wbps_scan_checker scan_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Output backpressure: stretches of stall or no stall, mostly short, a few
  // long. STALL_NONE gives runs with the receiver always ready.
  always @(posedge clk) begin
    if (!rst_n || stall_mode == STALL_NONE) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < ((stall_mode == STALL_HEAVY) ? 50 : 15));
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end
  end

  // Present one register write and wait for it to be taken; back-to-back calls
  // keep cfg_we high across the writes, program_regs drops it at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [4:0] which);
    if (which[0]) write_reg(REG_PATTERN_LO, set_lo);
    if (which[1]) write_reg(REG_PATTERN_HI, set_hi);
    if (which[2]) write_reg(REG_CARE_MASK, {48'd0, set_care});
    if (which[3]) write_reg(REG_PATTERN_LENGTH, {59'd0, set_len});
    if (which[4]) write_reg(REG_REGION_BASE, set_base);
    cfg_we <= 1'b0;
  endtask

  // Offer one byte after an optional gap and hold it until the transaction
  // completes. in_valid stays high on return so the next byte can follow
  // without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (rush || roll < 55) gap = 0;
    else if (roll < 90)    gap = $urandom_range(1, 3);
    else                   gap = $urandom_range(4, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_item.data_byte   <= b;
    in_item.last_byte   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, drain every expected result, then allow the pipeline to settle
  // in case the last byte caused no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    bytes_sent = 0;
  end

  initial begin
    int           phase;
    int           r;
    int           j;
    int           regions;
    int unsigned  elen;
    int unsigned  rl;
    int unsigned  off;
    int unsigned  flip;
    bit           close;
    logic [4:0]   which;
    logic [127:0] pat;
    logic [7:0]   region [$];

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PATTERN_LO;
    cfg_wdata <= '0;
    set_lo    = '0;
    set_hi    = '0;
    set_care  = 16'hFFFF;
    set_len   = 5'd1;
    set_base  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-byte pattern 0x00, no wildcards, base zero.
    // Match mid-region, then a byte ignored after the match closes the region.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    // Match on the last byte, then a one-byte region with no match.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Full-length pattern with wildcards at both ends, base at the top of the
    // address space.
    set_lo   = '1;
    set_hi   = 64'h8001_7F80_00FF_5AA5;
    set_care = 16'h7FFE;
    set_len  = 5'd16;
    set_base = '1;
    program_regs(5'b11111);
    // Region shorter than the pattern can never match.
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Exact match ending on the last byte; wildcard positions get random bytes.
    pat = {set_hi, set_lo};
    for (j = 0; j < 16; j++)
      send_byte(set_care[j] ? pat[8*j +: 8] : 8'($urandom), j == 15);
    wait_idle();

    // Random phases: new register settings, then a few regions, most of them
    // carrying a planted pattern instance.
    for (phase = 0; bytes_sent < 1550; phase++) begin
      which = (phase < 5) ? 5'b11111 : (5'b01000 | 5'($urandom));
      if (which[0]) begin
        case ($urandom_range(0, 3))
          0:       set_lo = '0;
          1:       set_lo = '1;
          default: set_lo = {$urandom, $urandom};
        endcase
      end
      if (which[1]) begin
        case ($urandom_range(0, 3))
          0:       set_hi = '0;
          1:       set_hi = '1;
          default: set_hi = {$urandom, $urandom};
        endcase
      end
      if (which[2]) begin
        case ($urandom_range(0, 4))
          0:       set_care = '0;
          1:       set_care = '1;
          default: set_care = 16'($urandom);
        endcase
      end
      // Walk the length extremes first: zero, over-range, minimum, full.
      case (phase)
        0: set_len = 5'd0;
        1: set_len = 5'd31;
        2: set_len = 5'd1;
        3: set_len = 5'd17;
        4: set_len = 5'd16;
        default: begin
          case ($urandom_range(0, 9))
            0:       set_len = 5'd0;
            1:       set_len = 5'd1;
            2:       set_len = 5'd16;
            3:       set_len = 5'($urandom_range(17, 31));
            default: set_len = 5'($urandom_range(2, 15));
          endcase
        end
      endcase
      if (which[4]) begin
        case ($urandom_range(0, 3))
          0:       set_base = '0;
          1:       set_base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 200);
          default: set_base = {$urandom, $urandom};
        endcase
      end
      program_regs(which);

      rush = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       stall_mode <= STALL_NONE;
        1:       stall_mode <= STALL_HEAVY;
        default: stall_mode <= STALL_LIGHT;
      endcase

      elen = (set_len == 0) ? 1 : ((set_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : set_len);
      pat  = {set_hi, set_lo};
      regions = $urandom_range(2, 6);
      for (r = 0; r < regions; r++) begin
        rl = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 250)
                                         : $urandom_range(1, 2 * elen + 8);
        region.delete();
        repeat (rl) region = {region, 8'($urandom)};
        if (rl >= elen && $urandom_range(0, 3) != 0) begin
          off = $urandom_range(0, rl - elen);
          for (j = 0; j < elen; j++)
            if (set_care[j]) region[off + j] = pat[8*j +: 8];
          if ($urandom_range(0, 3) == 0) begin
            // Near miss: corrupt one bit of the planted copy.
            flip = off + $urandom_range(0, elen - 1);
            region[flip] = region[flip] ^ 8'(1 << $urandom_range(0, 7));
          end
        end
        // Sometimes leave the final region open so the next settings land
        // mid-region.
        close = !(r == regions - 1 && $urandom_range(0, 3) == 0);
        for (j = 0; j < rl; j++)
          send_byte(region[j], close && (j == rl - 1));
        bytes_sent += rl;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/wbps_pkg.sv
rtl/core/wbps_cell.sv
rtl/core/wbps_skid.sv
rtl/core/wildcard_byte_pattern_search_unit.sv
rtl/core/wbps_checker.sv
tb/sv/wbps_scan_checker.sv
tb/sv/wildcard_byte_pattern_search_unit_tb.sv
